[src/zrld_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrld_pkg
// Shared constants and controller/datapath types for the zigzag run-length
// block decoder.
// ----------------------------------------------------------------------------
package zrld_pkg;

  // Default side length of a square coefficient block
  localparam int BLOCK_SIDE_DEF = 8;

  // Decoder phase codes: which kind of stream byte comes next
  localparam logic [1:0] PH_DC  = 2'd0;
  localparam logic [1:0] PH_RUN = 2'd1;
  localparam logic [1:0] PH_VAL = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic       latch;      // capture the incoming byte and end flag
    logic       emit_dc;    // update predictor, restart block, emit DC
    logic       emit_zero;  // advance and emit a zero coefficient
    logic       emit_val;   // advance and emit the sign-extended byte
    logic       dec_run;    // count down the pending run
    logic       store_run;  // hold the byte as the pending run
    logic       load_run;   // load the run counter from the pending run
    logic       phase_we;   // write phase_code into the phase register
    logic [1:0] phase_code;
    logic       done;       // close the byte; clear predictor on stream end
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] phase;
    logic       pos_full;   // every position of the block has been emitted
    logic       run_nz;     // zeros of the current run still pending
    logic       pair_zero;  // pending run and value byte are both zero
    logic       end_flag;   // latched byte carried the stream end mark
    logic       slot_free;  // output register can take a coefficient
  } sts_t;

endpackage

[src/zrld_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrld_in_if
// Stream byte channel: valid/ready handshake with byte and end mark.
// ----------------------------------------------------------------------------
interface zrld_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;
  logic       stream_end;

  modport source (output valid, output stream_byte, output stream_end, input ready);
  modport sink   (input valid, input stream_byte, input stream_end, output ready);
endinterface

[src/zrld_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrld_out_if
// Coefficient channel: valid/ready handshake with position, value and last.
// ----------------------------------------------------------------------------
interface zrld_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         coef_row;
  logic [2:0]         coef_col;
  logic signed [15:0] coef_value;
  logic               block_last;

  modport source (output valid, output coef_row, output coef_col, output coef_value,
                  output block_last, input ready);
  modport sink   (input valid, input coef_row, input coef_col, input coef_value,
                  input block_last, output ready);
endinterface

[src/zrld_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrld_dpath
// Datapath: DC predictor, zigzag walker, run counter and output register.
// ----------------------------------------------------------------------------
module zrld_dpath #(
  parameter int BLOCK_SIDE = zrld_pkg::BLOCK_SIDE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         stream_byte,
  input  logic               stream_end,
  input  zrld_pkg::cmd_t     cmd,
  output zrld_pkg::sts_t     sts,
  input  logic               coef_ready,
  output logic               coef_valid,
  output logic [2:0]         coef_row,
  output logic [2:0]         coef_col,
  output logic signed [15:0] coef_value,
  output logic               block_last
);

  localparam int RW   = $clog2(BLOCK_SIDE);
  localparam int AREA = BLOCK_SIDE * BLOCK_SIDE;
  localparam int PW   = $clog2(AREA + 1);
  localparam logic [RW-1:0] EDGE_IDX = RW'(BLOCK_SIDE - 1);
  localparam logic [PW-1:0] AREA_P   = PW'(AREA);

  logic [7:0]    byte_l;
  logic          end_l;
  logic [1:0]    phase;
  logic [15:0]   pred;
  logic [15:0]   pred_next;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_adv;
  logic [RW-1:0] row, col, row_adv, col_adv;
  logic          moving_up, mu_adv;
  logic [7:0]    pending;
  logic [6:0]    run_cnt;
  logic [15:0]   byte_ext;
  logic          slot_free;

  assign byte_ext  = {{8{byte_l[7]}}, byte_l};
  assign pred_next = pred + byte_ext;
  assign pos_adv   = pos + 1'b1;
  assign slot_free = !coef_valid || coef_ready;

  // Next zigzag position
  always_comb begin
    row_adv = row;
    col_adv = col;
    mu_adv  = moving_up;
    if (moving_up) begin
      if (col == EDGE_IDX) begin
        row_adv = row + 1'b1;
        mu_adv  = 1'b0;
      end else if (row == '0) begin
        col_adv = col + 1'b1;
        mu_adv  = 1'b0;
      end else begin
        row_adv = row - 1'b1;
        col_adv = col + 1'b1;
      end
    end else begin
      if (row == EDGE_IDX) begin
        col_adv = col + 1'b1;
        mu_adv  = 1'b1;
      end else if (col == '0) begin
        row_adv = row + 1'b1;
        mu_adv  = 1'b1;
      end else begin
        row_adv = row + 1'b1;
        col_adv = col - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= zrld_pkg::PH_DC;
      pred       <= '0;
      pos        <= '0;
      row        <= '0;
      col        <= '0;
      moving_up  <= 1'b1;
      pending    <= '0;
      run_cnt    <= '0;
      end_l      <= 1'b0;
      coef_valid <= 1'b0;
    end else begin
      if (cmd.latch) begin
        end_l <= stream_end;
      end
      if (cmd.store_run) begin
        pending <= byte_l;
      end
      if (cmd.load_run) begin
        run_cnt <= pending[7] ? 7'd0 : pending[6:0];
      end else if (cmd.dec_run) begin
        run_cnt <= run_cnt - 1'b1;
      end
      if (cmd.phase_we) begin
        phase <= cmd.phase_code;
      end
      if (cmd.done && end_l) begin
        pred <= '0;
      end else if (cmd.emit_dc) begin
        pred <= pred_next;
      end

      if (cmd.emit_dc) begin
        row       <= '0;
        col       <= '0;
        moving_up <= 1'b1;
        pos       <= PW'(1);
      end else if (cmd.emit_zero || cmd.emit_val) begin
        row       <= row_adv;
        col       <= col_adv;
        moving_up <= mu_adv;
        pos       <= pos_adv;
      end

      if (cmd.emit_dc || cmd.emit_zero || cmd.emit_val) begin
        coef_valid <= 1'b1;
      end else if (coef_ready) begin
        coef_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      byte_l <= stream_byte;
    end
    if (cmd.emit_dc) begin
      coef_row   <= 3'd0;
      coef_col   <= 3'd0;
      coef_value <= pred_next;
      block_last <= (PW'(1) >= AREA_P);
    end else if (cmd.emit_zero || cmd.emit_val) begin
      coef_row   <= 3'(row_adv);
      coef_col   <= 3'(col_adv);
      coef_value <= cmd.emit_val ? byte_ext : 16'sd0;
      block_last <= (pos_adv >= AREA_P);
    end
  end

  always_comb begin
    sts.phase     = phase;
    sts.pos_full  = (pos >= AREA_P);
    sts.run_nz    = (run_cnt != '0);
    sts.pair_zero = (pending == '0) && (byte_l == '0);
    sts.end_flag  = end_l;
    sts.slot_free = slot_free;
  end

endmodule

[src/zrld_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zrld_ctrl
// Controller: sequences each stream byte into DC, zero-run, value and fill
// steps, one coefficient per step.
// ----------------------------------------------------------------------------
module zrld_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  zrld_pkg::sts_t sts,
  output zrld_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_ZEROS  = 3'd2;
  localparam logic [2:0] S_TAIL   = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;

  logic [2:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        case (sts.phase)
          zrld_pkg::PH_RUN: begin
            cmd.store_run  = 1'b1;
            cmd.phase_we   = 1'b1;
            cmd.phase_code = zrld_pkg::PH_VAL;
            state_next     = sts.end_flag ? S_FILL : S_IDLE;
          end
          zrld_pkg::PH_VAL: begin
            if (sts.pair_zero) begin
              state_next = S_FILL;
            end else begin
              cmd.load_run = 1'b1;
              state_next   = S_ZEROS;
            end
          end
          default: begin
            // DC byte; the unused phase code is read the same way
            if (sts.slot_free) begin
              cmd.emit_dc    = 1'b1;
              cmd.phase_we   = 1'b1;
              cmd.phase_code = zrld_pkg::PH_RUN;
              state_next     = sts.end_flag ? S_FILL : S_IDLE;
            end
          end
        endcase
      end
      S_ZEROS: begin
        if (sts.run_nz && !sts.pos_full) begin
          if (sts.slot_free) begin
            cmd.emit_zero = 1'b1;
            cmd.dec_run   = 1'b1;
          end
        end else if (!sts.pos_full) begin
          if (sts.slot_free) begin
            cmd.emit_val = 1'b1;
            state_next   = S_TAIL;
          end
        end else begin
          state_next = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd.phase_we   = 1'b1;
        cmd.phase_code = sts.pos_full ? zrld_pkg::PH_DC : zrld_pkg::PH_RUN;
        state_next     = sts.end_flag ? S_FILL : S_IDLE;
      end
      S_FILL: begin
        if (!sts.pos_full) begin
          if (sts.slot_free) begin
            cmd.emit_zero = 1'b1;
          end
        end else begin
          cmd.phase_we   = 1'b1;
          cmd.phase_code = zrld_pkg::PH_DC;
          cmd.done       = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

[src/zigzag_run_length_block_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zigzag_run_length_block_decoder
// Expands a run-length byte stream into zigzag-ordered block coefficients.
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake     payload
//   stream   in   valid/ready   stream_byte[7:0], stream_end
//   coef     out  valid/ready   coef_row[2:0], coef_col[2:0],
//                               coef_value[15:0] signed, block_last
//
// One byte is worked on at a time. A run byte is held as the pending run and a
// DC byte emits the DC coefficient; a value byte emits the zeros of its run and
// then the value while the block has room, and a (0,0) pair emits the fill
// coefficients. A stream end also emits the fill coefficients and then closes
// the byte. The output register sends at most one coefficient per cycle.
// Reset (rst, synchronous) clears the predictor, the walker and the phase.
// A stalled coef channel holds the controller in place; stream stays low on
// ready until the current byte is fully expanded.
// ----------------------------------------------------------------------------
module zigzag_run_length_block_decoder #(
  parameter int BLOCK_SIDE = zrld_pkg::BLOCK_SIDE_DEF
) (
  input  logic       clk,
  input  logic       rst,
  zrld_in_if.sink    stream,
  zrld_out_if.source coef
);

  // Command and status bundles between the controller and the datapath
  zrld_pkg::cmd_t cmd;
  zrld_pkg::sts_t sts;

  // Controller: accept a transaction, then step through its coefficients
  zrld_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: hold the predictor and zigzag position, drive the output register
  zrld_dpath #(
    .BLOCK_SIDE (BLOCK_SIDE)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .stream_byte (stream.stream_byte),
    .stream_end  (stream.stream_end),
    .cmd         (cmd),
    .sts         (sts),
    .coef_ready  (coef.ready),
    .coef_valid  (coef.valid),
    .coef_row    (coef.coef_row),
    .coef_col    (coef.coef_col),
    .coef_value  (coef.coef_value),
    .block_last  (coef.block_last)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the zigzag run-length block decoder. Feeds stream
// bytes over the input channel, predicts every zigzag coefficient from its own
// behavioral decoder, and compares each coefficient transaction on the output
// channel in order. Covers a directed table of corner cases followed by
// random well-formed blocks mixed with noise, with random idling on both
// channels, one long output hold-off and one sender pause until drained.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SIDE       = zrld_pkg::BLOCK_SIDE_DEF;
  localparam int AREA       = SIDE * SIDE;
  localparam int RAND_BYTES = 256;
  localparam int LONG_HOLD  = 400;      // cycles of the long output hold-off
  localparam int DRAIN_WAIT = 16;       // settle time after the last coefficient
  localparam int MAX_CYCLES = 400000;   // generous run limit
  localparam int SHOW_MAX   = 10;       // mismatches printed in full

  // One coefficient as it leaves the block
  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [15:0] value;
    logic               last;
  } coef_t;

  // One row of the directed table; want is used only when typed is set
  typedef struct {
    logic [7:0] b;
    logic       e;
    bit         typed;
    coef_t      want;
  } stim_row_t;

  logic clk;
  logic rst;

  coef_t fresh_coefs[$];   // coefficients settled by the byte just decoded
  coef_t due_coefs[$];     // coefficients predicted and not yet seen

  zrld_in_if  byte_ch ();
  zrld_out_if coef_ch ();

  zigzag_run_length_block_decoder #(
    .BLOCK_SIDE(SIDE)
  ) dut (
    .clk   (clk),
    .rst   (rst),
    .stream(byte_ch),
    .coef  (coef_ch)
  );

  // --------------------------------------------------------------------------
  // Clock and cycle limit
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d coefficients still due",
               cycles, due_coefs.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Predictor: a behavioral zigzag run-length decoder with its own state
  // --------------------------------------------------------------------------
  logic [1:0]  zz_phase;
  logic [15:0] dc_pred;
  int          pos_cnt;
  int          zz_row;
  int          zz_col;
  bit          zz_up;
  logic [7:0]  pend_run;

  // Step one position along the zigzag path
  function automatic void zz_walk();
    if (zz_up) begin
      if (zz_col == SIDE - 1) begin
        zz_row++;
        zz_up = 1'b0;
      end else if (zz_row == 0) begin
        zz_col++;
        zz_up = 1'b0;
      end else begin
        zz_row--;
        zz_col++;
      end
    end else begin
      if (zz_row == SIDE - 1) begin
        zz_col++;
        zz_up = 1'b1;
      end else if (zz_col == 0) begin
        zz_row++;
        zz_up = 1'b1;
      end else begin
        zz_row++;
        zz_col--;
      end
    end
    pos_cnt++;
  endfunction

  function automatic void zz_emit(input logic [15:0] value);
    coef_t c;
    c.row   = zz_row[2:0];
    c.col   = zz_col[2:0];
    c.value = value;
    c.last  = (pos_cnt >= AREA);
    fresh_coefs = {fresh_coefs, c};
  endfunction

  // Zero out every position left in the open block
  function automatic void zz_fill();
    while (pos_cnt < AREA) begin
      zz_walk();
      zz_emit(16'd0);
    end
  endfunction

  function automatic void zz_clear();
    zz_phase = zrld_pkg::PH_DC;
    dc_pred  = 16'd0;
    pos_cnt  = 0;
    zz_row   = 0;
    zz_col   = 0;
    zz_up    = 1'b1;
    pend_run = 8'd0;
  endfunction

  // Decode one stream byte into fresh_coefs
  function automatic void expand_byte(input logic [7:0] b, input logic e);
    logic [15:0] ext;
    int          run;
    ext = {{8{b[7]}}, b};
    fresh_coefs.delete();
    if (zz_phase == zrld_pkg::PH_RUN) begin
      pend_run = b;
      zz_phase = zrld_pkg::PH_VAL;
    end else if (zz_phase == zrld_pkg::PH_VAL) begin
      if (pend_run == 8'd0 && b == 8'd0) begin
        // end-of-block pair: zero the rest
        zz_fill();
        zz_phase = zrld_pkg::PH_DC;
      end else begin
        // negative runs emit no zeros
        run = pend_run[7] ? 0 : int'(pend_run);
        while (run > 0 && pos_cnt < AREA) begin
          zz_walk();
          zz_emit(16'd0);
          run--;
        end
        // a run past the block end drops the value
        if (pos_cnt < AREA) begin
          zz_walk();
          zz_emit(ext);
        end
        zz_phase = (pos_cnt >= AREA) ? zrld_pkg::PH_DC : zrld_pkg::PH_RUN;
      end
    end else begin
      // DC byte, also taken for the unused phase code
      dc_pred  = dc_pred + ext;
      zz_row   = 0;
      zz_col   = 0;
      zz_up    = 1'b1;
      pos_cnt  = 1;
      zz_emit(dc_pred);
      zz_phase = (pos_cnt >= AREA) ? zrld_pkg::PH_DC : zrld_pkg::PH_RUN;
    end
    if (e) begin
      // stream end flushes the open block; a lone run byte is simply dropped
      if (zz_phase != zrld_pkg::PH_DC) zz_fill();
      dc_pred  = 16'd0;
      zz_phase = zrld_pkg::PH_DC;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Output side: idling and checking
  // --------------------------------------------------------------------------
  bit calm      = 1'b0;   // no idling in this stretch
  bit tail      = 1'b0;   // last part of the run, no idling at all
  bit hold_coef = 1'b0;   // request for the long output hold-off
  int errors    = 0;

  initial begin
    int idle_left;
    idle_left      = 0;
    coef_ch.ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_coef) begin
        // hold off long enough for the block to fill up and stall its input
        coef_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_coef = 1'b0;
      end
      if (idle_left == 0 && !calm && !tail && $urandom_range(0, 6) == 0)
        idle_left = $urandom_range(1, 4);
      if (idle_left > 0) begin
        coef_ch.ready <= 1'b0;
        idle_left--;
      end else begin
        coef_ch.ready <= 1'b1;
      end
    end
  end

  // Compare each coefficient transaction against the oldest prediction
  always @(posedge clk) begin
    coef_t got;
    coef_t want;
    if (!rst && coef_ch.valid && coef_ch.ready) begin
      got.row   = coef_ch.coef_row;
      got.col   = coef_ch.coef_col;
      got.value = coef_ch.coef_value;
      got.last  = coef_ch.block_last;
      if (due_coefs.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("unexpected coef: row %0d col %0d value %0d last %0b",
                   got.row, got.col, got.value, got.last);
      end else begin
        want = due_coefs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= SHOW_MAX)
            $display("coef mismatch: exp %0d/%0d %0d %0b, got %0d/%0d %0d %0b",
                     want.row, want.col, want.value, want.last,
                     got.row, got.col, got.value, got.last);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------

  // Offer one byte, hold it until accepted, then queue its coefficients.
  // Entered and left at a falling edge.
  task automatic put_byte(input logic [7:0] b, input logic e, input bit typed,
                          input coef_t want);
    if (!calm && !tail && $urandom_range(0, 5) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.stream_byte <= b;
    byte_ch.stream_end  <= e;
    do @(posedge clk); while (!byte_ch.ready);
    expand_byte(b, e);
    // where the first coefficient is known by inspection, check against it
    if (typed) begin
      if (fresh_coefs.size() == 0) fresh_coefs = {want};
      else fresh_coefs[0] = want;
    end
    due_coefs = {due_coefs, fresh_coefs};
    @(negedge clk);
  endtask

  stim_row_t stim_rows[$];

  function automatic void add_row(input logic [7:0] b, input logic e, input bit typed,
                                  input int row, input int col, input int value,
                                  input logic last);
    stim_row_t r;
    r.b          = b;
    r.e          = e;
    r.typed      = typed;
    r.want.row   = row[2:0];
    r.want.col   = col[2:0];
    r.want.value = value[15:0];
    r.want.last  = last;
    stim_rows    = {stim_rows, r};
  endfunction

  initial begin
    logic [7:0] b;
    logic       e;
    bit         zero_val;
    coef_t      none;

    none     = '0;
    zero_val = 1'b0;
    rst      = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.stream_byte = 8'd0;
    byte_ch.stream_end  = 1'b0;
    zz_clear();

    // Directed table: byte, end, typed, then row/col/value/last of the first
    // coefficient where it can be read off by hand
    add_row(8'h7F, 1'b0, 1, 0, 0, 127, 1'b0);     // largest positive DC step
    add_row(8'h00, 1'b0, 0, 0, 0, 0, 1'b0);       // zero run
    add_row(8'h80, 1'b0, 1, 0, 1, -128, 1'b0);    // most negative AC value
    add_row(8'h80, 1'b0, 0, 0, 0, 0, 1'b0);       // negative run, no zeros
    add_row(8'h7F, 1'b0, 1, 1, 0, 127, 1'b0);     // largest AC value
    add_row(8'h05, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h01, 1'b0, 0, 0, 0, 0, 1'b0);       // five zeros then one
    add_row(8'h00, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h00, 1'b0, 0, 0, 0, 0, 1'b0);       // end-of-block pair
    add_row(8'h80, 1'b0, 1, 0, 0, -1, 1'b0);      // predictor goes negative
    add_row(8'h7F, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h55, 1'b0, 0, 0, 0, 0, 1'b0);       // run past block end, value dropped
    add_row(8'hFF, 1'b1, 1, 0, 0, -2, 1'b0);      // DC with stream end: flush
    add_row(8'h01, 1'b0, 1, 0, 0, 1, 1'b0);       // predictor was cleared
    add_row(8'h03, 1'b1, 1, 0, 1, 0, 1'b0);       // lone trailing run byte
    add_row(8'h00, 1'b0, 1, 0, 0, 0, 1'b0);
    add_row(8'h02, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'hFF, 1'b1, 0, 0, 0, 0, 1'b0);       // value with stream end
    add_row(8'h80, 1'b0, 1, 0, 0, -128, 1'b0);    // most negative DC step
    add_row(8'h3E, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h12, 1'b0, 0, 0, 0, 0, 1'b0);       // value lands on last position
    add_row(8'hAA, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h00, 1'b0, 0, 0, 0, 0, 1'b0);
    add_row(8'h00, 1'b1, 0, 0, 0, 0, 1'b0);       // end pair together with stream end

    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (stim_rows[k])
      put_byte(stim_rows[k].b, stim_rows[k].e, stim_rows[k].typed, stim_rows[k].want);

    // Random part: mostly well-formed blocks with random content, some noise
    for (int i = 0; i < RAND_BYTES; i++) begin
      calm = ((i / 40) % 3 == 1);
      tail = (i >= RAND_BYTES - 40);
      if (i == 60) hold_coef = 1'b1;
      if (i == 150) begin
        // pause until every predicted coefficient has come out
        byte_ch.valid <= 1'b0;
        while (due_coefs.size() != 0) @(negedge clk);
        @(negedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        b        = 8'($urandom_range(0, 255));
        zero_val = 1'b0;
      end else if (zz_phase == zrld_pkg::PH_RUN) begin
        case ($urandom_range(0, 19))
          0:       b = 8'h00;
          1:       b = 8'h80 | 8'($urandom_range(0, 127));
          2:       b = 8'($urandom_range(0, 127));
          default: b = 8'($urandom_range(0, 6));
        endcase
        zero_val = (b == 8'h00) && ($urandom_range(0, 1) == 0);
      end else if (zz_phase == zrld_pkg::PH_VAL && zero_val) begin
        b        = 8'h00;
        zero_val = 1'b0;
      end else begin
        b        = 8'($urandom_range(0, 255));
        zero_val = 1'b0;
      end
      e = ($urandom_range(0, 39) == 0);
      put_byte(b, e, 1'b0, none);
    end
    byte_ch.valid <= 1'b0;

    // Drain and let the block settle
    while (due_coefs.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
